FILE: design/arpdhcp_pkg.sv
// Shared types and constants for the ARP/DHCP reply engine.
package arpdhcp_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [31:0] DHCP_COOKIE  = 32'h6382_5363;
  localparam logic [7:0]  IP_VER_IHL   = 8'h45;
  localparam logic [15:0] PORT_SERVER  = 16'd67;
  localparam logic [15:0] PORT_CLIENT  = 16'd68;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  MSG_DISCOVER = 8'd1;
  localparam logic [7:0]  MSG_OFFER    = 8'd2;
  localparam logic [7:0]  MSG_REQUEST  = 8'd3;
  localparam logic [7:0]  MSG_ACK      = 8'd5;
  localparam logic [15:0] ARP_OP_REQ   = 16'd1;

  localparam logic [5:0] ARP_WORDS  = 6'd6;   // 42 bytes
  localparam logic [5:0] DHCP_WORDS = 6'd43;  // 342 bytes
  localparam logic [3:0] ARP_TAIL   = 4'd2;
  localparam logic [3:0] DHCP_TAIL  = 4'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BRIDGE_MAC = 3'd0;
  localparam logic [2:0] CFG_GATEWAY_IP = 3'd1;
  localparam logic [2:0] CFG_DNS_IP     = 3'd2;
  localparam logic [2:0] CFG_LEASE_IP   = 3'd3;
  localparam logic [2:0] CFG_SUBNET     = 3'd4;
  localparam logic [2:0] CFG_LEASE_SEC  = 3'd5;

  typedef enum logic [1:0] {
    KIND_ARP   = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_ACK   = 2'd2
  } reply_kind_e;

  typedef struct packed {
    logic [47:0] bridge_mac;
    logic [31:0] gateway_ip;
    logic [31:0] dns_ip;
    logic [31:0] lease_ip;
    logic [31:0] subnet_mask;
    logic [31:0] lease_seconds;
  } cfg_t;

  // One reply job handed from the parser to the generator.
  typedef struct packed {
    reply_kind_e kind;
    logic [47:0] sender_hw;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] client_hw;
    logic [31:0] xid;
  } job_t;

endpackage

FILE: design/arpdhcp_if.sv
// Channel interfaces: frame bytes in, reply words out, configuration writes.
interface arpdhcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink (input valid, frame_byte, end_of_frame, output ready);
endinterface

interface arpdhcp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] reply_word;
  logic [3:0]  valid_bytes;
  logic [1:0]  reply_kind;
  logic        last_word;
  modport source (output valid, reply_word, valid_bytes, reply_kind, last_word, input ready);
  modport sink (input valid, reply_word, valid_bytes, reply_kind, last_word, output ready);
endinterface

interface arpdhcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/arpdhcp_front.sv
// Byte-serial frame parser: field capture, option walk, reply decision.
module arpdhcp_front #(
  parameter int unsigned OFFSET_BITS = arpdhcp_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          byte_i,
  input  logic                eof_i,
  input  arpdhcp_pkg::cfg_t   cfg_i,
  output logic                push_o,
  output arpdhcp_pkg::job_t   job_o,
  output logic                busy_o
);
  import arpdhcp_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0] off_q, off_d, len_q;
  logic [15:0] eth_q, eth_d, op_q, op_d, port_q, port_d;
  logic [47:0] shw_q, shw_d, chw_q, chw_d;
  logic [31:0] sip_q, sip_d, tip_q, tip_d, xid_q, xid_d, cookie_q, cookie_d;
  logic [5:0]  ihb_q, ihb_d;
  logic [7:0]  proto_q, proto_d;
  logic [1:0]  ph_q, ph_d;
  logic [7:0]  code_q, code_d, left_q, left_d, pend_q, pend_d, mt_q, mt_d, mtf_q;
  logic        eof_q;

  logic [15:0] p;
  logic [15:0] u, d;
  logic        cap;
  logic [7:0]  left_m1;

  assign cap = (off_q != OFF_MAX);
  assign p   = 16'(off_q);
  assign u   = 16'd14 + 16'(ihb_q);
  assign d   = u + 16'd8;
  assign left_m1 = left_q - 8'd1;

  always_comb begin
    off_d = off_q; eth_d = eth_q; op_d = op_q; shw_d = shw_q; sip_d = sip_q;
    tip_d = tip_q; ihb_d = ihb_q; proto_d = proto_q; port_d = port_q;
    xid_d = xid_q; chw_d = chw_q; cookie_d = cookie_q;
    ph_d = ph_q; code_d = code_q; left_d = left_q; pend_d = pend_q; mt_d = mt_q;
    if (beat_i && cap) begin
      off_d = off_q + 1'b1;
      if (p == 16'd12 || p == 16'd13) eth_d = {eth_q[7:0], byte_i};
      if (p == 16'd20 || p == 16'd21) op_d = {op_q[7:0], byte_i};
      if (p >= 16'd22 && p <= 16'd27) shw_d = {shw_q[39:0], byte_i};
      if (p >= 16'd28 && p <= 16'd31) sip_d = {sip_q[23:0], byte_i};
      if (p >= 16'd38 && p <= 16'd41) tip_d = {tip_q[23:0], byte_i};
      if (p == 16'd14) ihb_d = {byte_i[3:0], 2'b00};
      if (p == 16'd23) proto_d = byte_i;
      if (p == u + 16'd2 || p == u + 16'd3) port_d = {port_q[7:0], byte_i};
      if (p >= d + 16'd4 && p <= d + 16'd7) xid_d = {xid_q[23:0], byte_i};
      if (p >= d + 16'd28 && p <= d + 16'd33) chw_d = {chw_q[39:0], byte_i};
      if (p >= d + 16'd236 && p <= d + 16'd239) cookie_d = {cookie_q[23:0], byte_i};
      if (p >= d + 16'd240) begin
        case (ph_q)
          2'd0: begin
            if (code_q != OPT_END && byte_i != 8'd0) begin
              code_d = byte_i;
              if (byte_i != OPT_END) ph_d = 2'd1;
            end
          end
          2'd1: begin
            if (byte_i == 8'd0) ph_d = 2'd0;
            else begin
              left_d = byte_i;
              ph_d = 2'd2;
            end
          end
          default: begin
            if (ph_q == 2'd2) pend_d = byte_i;
            left_d = left_m1;
            if (left_m1 == 8'd0) begin
              if (code_q == OPT_MSG_TYPE) mt_d = (ph_q == 2'd2) ? byte_i : pend_q;
              ph_d = 2'd0;
            end else begin
              ph_d = 2'd3;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; eth_q <= '0; op_q <= '0; shw_q <= '0; sip_q <= '0; tip_q <= '0;
      ihb_q <= '0; proto_q <= '0; port_q <= '0; xid_q <= '0; chw_q <= '0;
      cookie_q <= '0; ph_q <= '0; code_q <= '0; left_q <= '0; pend_q <= '0;
      mt_q <= '0; eof_q <= 1'b0;
    end else begin
      eth_q <= eth_d; op_q <= op_d; shw_q <= shw_d; sip_q <= sip_d; tip_q <= tip_d;
      ihb_q <= ihb_d; proto_q <= proto_d; port_q <= port_d; xid_q <= xid_d;
      chw_q <= chw_d; cookie_q <= cookie_d;
      eof_q <= beat_i && eof_i;
      if (beat_i && eof_i) begin
        off_q <= '0; ph_q <= '0; code_q <= '0; left_q <= '0; pend_q <= '0; mt_q <= '0;
      end else begin
        off_q <= off_d; ph_q <= ph_d; code_q <= code_d; left_q <= left_d;
        pend_q <= pend_d; mt_q <= mt_d;
      end
    end
  end

  // Frame length and final message type, held for the decision cycle.
  always_ff @(posedge clk_i) begin
    if (beat_i && eof_i) begin
      len_q <= off_d;
      mtf_q <= mt_d;
    end
  end

  // Decision in the cycle after the last byte; the next frame's first bytes
  // never touch captured fields, so they are still those of this frame.
  logic [15:0] len;
  logic arp_hit, dhcp_ok;
  assign len = 16'(len_q);
  assign arp_hit = (eth_q == ETH_ARP) && (len >= 16'd42) && (op_q == ARP_OP_REQ) &&
                   (tip_q == cfg_i.gateway_ip || tip_q == cfg_i.dns_ip);
  assign dhcp_ok = (eth_q == ETH_IPV4) && (len >= 16'd34) && (proto_q == PROTO_UDP) &&
                   (port_q == PORT_SERVER) && (len >= 16'd262 + 16'(ihb_q)) &&
                   (cookie_q == DHCP_COOKIE);

  always_comb begin
    job_o.sender_hw = shw_q;
    job_o.sender_ip = sip_q;
    job_o.target_ip = tip_q;
    job_o.client_hw = chw_q;
    job_o.xid       = xid_q;
    job_o.kind      = KIND_ARP;
    push_o          = 1'b0;
    if (eof_q && len >= 16'd14) begin
      if (eth_q == ETH_ARP) begin
        push_o = arp_hit;
      end else if (dhcp_ok && mtf_q == MSG_DISCOVER) begin
        push_o = 1'b1;
        job_o.kind = KIND_OFFER;
      end else if (dhcp_ok && mtf_q == MSG_REQUEST) begin
        push_o = 1'b1;
        job_o.kind = KIND_ACK;
      end
    end
  end

  assign busy_o = eof_q;
endmodule

FILE: design/arpdhcp_queue.sv
// Short job queue between parser and generator.
module arpdhcp_queue #(
  parameter int unsigned DEPTH = arpdhcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  arpdhcp_pkg::job_t         job_i,
  input  logic                      pop_i,
  output arpdhcp_pkg::job_t         job_o,
  output logic                      empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import arpdhcp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= nxt(wp_q);
      if (pop_i) rp_q <= nxt(rp_q);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign job_o   = mem[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

FILE: design/arpdhcp_back.sv
// Reply generator: builds the reply frame one 64-bit word per beat.
module arpdhcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arpdhcp_pkg::cfg_t cfg_i,
  input  logic              empty_i,
  input  arpdhcp_pkg::job_t job_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [63:0]       word_o,
  output logic [3:0]        nbytes_o,
  output logic [1:0]        kind_o,
  output logic              last_o
);
  import arpdhcp_pkg::*;

  logic        act_q;
  job_t        job_q;
  logic [5:0]  k_q;
  logic        ov_q;
  logic [63:0] w_q;
  logic [3:0]  n_q;
  logic [1:0]  kd_q;
  logic        l_q;
  logic [15:0] csum;
  logic [7:0]  mtype;

  // IP header checksum: fixed words plus the server address halves.
  logic [19:0] s0;
  logic [16:0] s1;
  assign s0 = 20'h28657 + 20'(cfg_i.gateway_ip[31:16]) + 20'(cfg_i.gateway_ip[15:0]);
  assign s1 = 17'(s0[15:0]) + 17'(s0[19:16]);
  assign csum = ~(s1[15:0] + 16'(s1[16]));
  assign mtype = (job_q.kind == KIND_ACK) ? MSG_ACK : MSG_OFFER;

  function automatic logic in_rng(input logic [8:0] i, input int unsigned lo,
                                  input int unsigned n);
    return (i >= 9'(lo)) && (i < 9'(lo + n));
  endfunction

  function automatic logic [7:0] b48(input logic [47:0] v, input logic [8:0] i,
                                     input int unsigned lo);
    logic [2:0] j;
    j = 3'(i - 9'(lo));
    return 8'(v >> (6'd40 - {j, 3'b000}));
  endfunction

  function automatic logic [7:0] b32(input logic [31:0] v, input logic [8:0] i,
                                     input int unsigned lo);
    logic [1:0] j;
    j = 2'(i - 9'(lo));
    return 8'(v >> (5'd24 - {j, 3'b000}));
  endfunction

  function automatic logic [7:0] arp_byte(input logic [8:0] i, input job_t jb,
                                          input cfg_t c);
    logic [7:0] r;
    r = 8'd0;
    if (in_rng(i, 0, 6)) r = b48(jb.sender_hw, i, 0);
    else if (in_rng(i, 6, 6)) r = b48(c.bridge_mac, i, 6);
    else if (i == 9'd12) r = ETH_ARP[15:8];
    else if (i == 9'd13) r = ETH_ARP[7:0];
    else if (i == 9'd15) r = 8'd1;
    else if (i == 9'd16) r = ETH_IPV4[15:8];
    else if (i == 9'd18) r = 8'd6;
    else if (i == 9'd19) r = 8'd4;
    else if (i == 9'd21) r = 8'd2;
    else if (in_rng(i, 22, 6)) r = b48(c.bridge_mac, i, 22);
    else if (in_rng(i, 28, 4)) r = b32(jb.target_ip, i, 28);
    else if (in_rng(i, 32, 6)) r = b48(jb.sender_hw, i, 32);
    else if (in_rng(i, 38, 4)) r = b32(jb.sender_ip, i, 38);
    return r;
  endfunction

  function automatic logic [7:0] dhcp_byte(input logic [8:0] i, input job_t jb,
                                           input cfg_t c, input logic [15:0] cs,
                                           input logic [7:0] mt);
    logic [7:0] r;
    r = 8'd0;
    if (in_rng(i, 0, 6)) r = b48(jb.client_hw, i, 0);
    else if (in_rng(i, 6, 6)) r = b48(c.bridge_mac, i, 6);
    else if (i == 9'd12) r = ETH_IPV4[15:8];
    else if (i == 9'd14) r = IP_VER_IHL;
    else if (i == 9'd16) r = 8'h01;
    else if (i == 9'd17) r = 8'h48;
    else if (i == 9'd22) r = 8'd64;
    else if (i == 9'd23) r = PROTO_UDP;
    else if (i == 9'd24) r = cs[15:8];
    else if (i == 9'd25) r = cs[7:0];
    else if (in_rng(i, 26, 4)) r = b32(c.gateway_ip, i, 26);
    else if (in_rng(i, 30, 4)) r = 8'hFF;
    else if (i == 9'd35) r = PORT_SERVER[7:0];
    else if (i == 9'd37) r = PORT_CLIENT[7:0];
    else if (i == 9'd38) r = 8'h01;
    else if (i == 9'd39) r = 8'h34;
    else if (i == 9'd42) r = 8'd2;
    else if (i == 9'd43) r = 8'd1;
    else if (i == 9'd44) r = 8'd6;
    else if (in_rng(i, 46, 4)) r = b32(jb.xid, i, 46);
    else if (in_rng(i, 58, 4)) r = b32(c.lease_ip, i, 58);
    else if (in_rng(i, 62, 4)) r = b32(c.gateway_ip, i, 62);
    else if (in_rng(i, 70, 6)) r = b48(jb.client_hw, i, 70);
    else if (in_rng(i, 278, 4)) r = b32(DHCP_COOKIE, i, 278);
    else if (i == 9'd282) r = OPT_MSG_TYPE;
    else if (i == 9'd283) r = 8'd1;
    else if (i == 9'd284) r = mt;
    else if (i == 9'd285) r = 8'd54;
    else if (i == 9'd286) r = 8'd4;
    else if (in_rng(i, 287, 4)) r = b32(c.gateway_ip, i, 287);
    else if (i == 9'd291) r = 8'd51;
    else if (i == 9'd292) r = 8'd4;
    else if (in_rng(i, 293, 4)) r = b32(c.lease_seconds, i, 293);
    else if (i == 9'd297) r = 8'd1;
    else if (i == 9'd298) r = 8'd4;
    else if (in_rng(i, 299, 4)) r = b32(c.subnet_mask, i, 299);
    else if (i == 9'd303) r = 8'd3;
    else if (i == 9'd304) r = 8'd4;
    else if (in_rng(i, 305, 4)) r = b32(c.gateway_ip, i, 305);
    else if (i == 9'd309) r = 8'd6;
    else if (i == 9'd310) r = 8'd4;
    else if (in_rng(i, 311, 4)) r = b32(c.dns_ip, i, 311);
    else if (i == 9'd315) r = OPT_END;
    return r;
  endfunction

  logic        is_arp, last_k, adv;
  logic [3:0]  n_k;
  logic [63:0] w_k;

  assign is_arp = (job_q.kind == KIND_ARP);
  assign last_k = is_arp ? (k_q == ARP_WORDS - 6'd1) : (k_q == DHCP_WORDS - 6'd1);
  assign n_k    = !last_k ? 4'd8 : (is_arp ? ARP_TAIL : DHCP_TAIL);
  assign adv    = act_q && (!ov_q || ready_i);
  assign pop_o  = !act_q && !empty_i;

  always_comb begin
    logic [8:0] idx;
    w_k = '0;
    for (int i = 0; i < 8; i++) begin
      idx = {k_q[5:0], 3'(i)};
      if (4'(i) < n_k)
        w_k[63 - 8*i -: 8] = is_arp ? arp_byte(idx, job_q, cfg_i)
                                    : dhcp_byte(idx, job_q, cfg_i, csum, mtype);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; k_q <= '0; ov_q <= 1'b0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        k_q <= '0;
      end else if (adv) begin
        k_q <= k_q + 6'd1;
        if (last_k) act_q <= 1'b0;
      end
      if (adv) ov_q <= 1'b1;
      else if (ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (adv) begin
      w_q <= w_k; n_q <= n_k; kd_q <= job_q.kind; l_q <= last_k;
    end
  end

  assign valid_o  = ov_q;
  assign word_o   = w_q;
  assign nbytes_o = n_q;
  assign kind_o   = kd_q;
  assign last_o   = l_q;
endmodule

FILE: design/arp_dhcp_reply_engine.sv
// Top level of the ARP/DHCP reply engine.
//
//  channel | dir | payload                                        | role
//  in_i    | in  | frame_byte, end_of_frame                       | frame bytes
//  out_o   | out | reply_word, valid_bytes, reply_kind, last_word | reply words
//  cfg_i   | in  | index, data                                    | register writes
//
// Input takes one byte per cycle while ready; a reply job is decided in the
// cycle after the last byte and queued. The generator sends one word per cycle
// while out_o is ready: 6 words for ARP, 43 for DHCP; it fetches each job from the queue between replies.
// Input stalls only while the job queue has no room for a decision in flight.
// Reset is asynchronous, active low; config registers reset to their defaults.
// Output beats come from a register; out_o ready stalls the generator, and through a full job queue the input.
module arp_dhcp_reply_engine #(
  parameter int unsigned OFFSET_BITS = arpdhcp_pkg::OFFSET_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = arpdhcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  arpdhcp_in_if.sink     in_i,
  arpdhcp_out_if.source  out_o,
  arpdhcp_cfg_if.sink    cfg_i
);
  import arpdhcp_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg_q;
  logic          push, pop, empty, busy, in_beat;
  job_t          job_in, job_out;
  logic [CW-1:0] count;

  // Configuration registers; always ready.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bridge_mac    <= 48'h0200_5E10_0002;
      cfg_q.gateway_ip    <= 32'h0A00_0202;
      cfg_q.dns_ip        <= 32'h0A00_0203;
      cfg_q.lease_ip      <= 32'h0A00_020F;
      cfg_q.subnet_mask   <= 32'hFFFF_FF00;
      cfg_q.lease_seconds <= 32'd86400;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BRIDGE_MAC: cfg_q.bridge_mac    <= cfg_i.data;
        CFG_GATEWAY_IP: cfg_q.gateway_ip    <= cfg_i.data[31:0];
        CFG_DNS_IP:     cfg_q.dns_ip        <= cfg_i.data[31:0];
        CFG_LEASE_IP:   cfg_q.lease_ip      <= cfg_i.data[31:0];
        CFG_SUBNET:     cfg_q.subnet_mask   <= cfg_i.data[31:0];
        CFG_LEASE_SEC:  cfg_q.lease_seconds <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // Keep a queue slot for a decision still in flight.
  assign in_i.ready = (32'(count) + 32'(busy)) < QUEUE_DEPTH;
  assign in_beat    = in_i.valid && in_i.ready;

  arpdhcp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (in_beat),
    .byte_i (in_i.frame_byte),
    .eof_i  (in_i.end_of_frame),
    .cfg_i  (cfg_q),
    .push_o (push),
    .job_o  (job_in),
    .busy_o (busy)
  );

  arpdhcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty),
    .count_o (count)
  );

  arpdhcp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .empty_i  (empty),
    .job_i    (job_out),
    .pop_o    (pop),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .word_o   (out_o.reply_word),
    .nbytes_o (out_o.valid_bytes),
    .kind_o   (out_o.reply_kind),
    .last_o   (out_o.last_word)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (32'(count) < QUEUE_DEPTH) || pop)
    else $error("job queue overflow");

  a_tail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_word |->
      out_o.valid_bytes == ARP_TAIL || out_o.valid_bytes == DHCP_TAIL)
    else $error("bad final word length");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last_word |-> out_o.valid_bytes == 4'd8)
    else $error("short word before end of reply");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.reply_kind != 2'd3)
    else $error("bad reply kind");

endmodule

FILE: dv/arp_dhcp_reply_engine_test.sv
// Self-checking testbench for the ARP/DHCP reply engine.
module arp_dhcp_reply_engine_test;
  import arpdhcp_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    reply_kind_e kind;
    logic        last;
  } reply_beat_t;

  // Byte-accurate model of the responder plus the queue of reply beats it predicts.
  class reply_scoreboard;
    logic [47:0] mac_reg;
    logic [31:0] gw_ip, dns_ip, lease_ip, mask_reg, lease_sec;
    int          offset, ip_hdr_len;
    logic [15:0] eth_type, arp_op, udp_port;
    logic [47:0] snd_hw, cli_hw;
    logic [31:0] snd_ip, tgt_ip, xid, cookie;
    logic [7:0]  proto, opt_code, opt_left, type_seen, dhcp_kind;
    logic [1:0]  opt_phase;
    logic [7:0]  txb [DHCP_WORDS*8];
    reply_beat_t pending[$];
    int          errors;

    function new();
      mac_reg = 48'h02005E100002; gw_ip = 32'h0A000202; dns_ip = 32'h0A000203;
      lease_ip = 32'h0A00020F; mask_reg = 32'hFFFFFF00; lease_sec = 32'd86400;
      offset = 0; ip_hdr_len = 0; eth_type = 0; arp_op = 0; udp_port = 0;
      snd_hw = 0; cli_hw = 0; snd_ip = 0; tgt_ip = 0; xid = 0; cookie = 0;
      proto = 0; errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = 0; opt_phase = 0; opt_code = 0; opt_left = 0; type_seen = 0; dhcp_kind = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        CFG_BRIDGE_MAC: mac_reg = v;
        CFG_GATEWAY_IP: gw_ip = v[31:0];
        CFG_DNS_IP:     dns_ip = v[31:0];
        CFG_LEASE_IP:   lease_ip = v[31:0];
        CFG_SUBNET:     mask_reg = v[31:0];
        CFG_LEASE_SEC:  lease_sec = v[31:0];
        default: ;
      endcase
    endfunction

    function void put(int at, logic [63:0] v, int nb);
      for (int i = 0; i < nb; i++) txb[at + i] = v[8*(nb-1-i) +: 8];
    endfunction

    // Slice the reply buffer into big-endian words, tail bytes zero.
    function void emit(int len, reply_kind_e kind);
      int words, n;
      reply_beat_t bt;
      words = (len + 7) / 8;
      for (int k = 0; k < words; k++) begin
        n = (len - 8*k > 8) ? 8 : len - 8*k;
        bt.word = '0;
        for (int i = 0; i < 8; i++) bt.word = {bt.word[55:0], (i < n) ? txb[8*k+i] : 8'h00};
        bt.nbytes = 4'(n);
        bt.kind = kind;
        bt.last = (k + 1 == words);
        pending.push_back(bt);
      end
    endfunction

    function void build_dhcp(logic [7:0] msg, reply_kind_e kind);
      logic [31:0] sum;
      foreach (txb[i]) txb[i] = 8'h00;
      put(0, cli_hw, 6); put(6, mac_reg, 6); put(12, ETH_IPV4, 2);
      put(14, IP_VER_IHL, 1); put(16, 328, 2); put(22, 64, 1); put(23, PROTO_UDP, 1);
      put(26, gw_ip, 4); put(30, 32'hFFFFFFFF, 4);
      put(34, PORT_SERVER, 2); put(36, PORT_CLIENT, 2); put(38, 308, 2);
      put(42, 2, 1); put(43, 1, 1); put(44, 6, 1); put(46, xid, 4);
      put(58, lease_ip, 4); put(62, gw_ip, 4); put(70, cli_hw, 6);
      put(278, DHCP_COOKIE, 4);
      put(282, {OPT_MSG_TYPE, 8'd1, msg}, 3);
      put(285, {8'd54, 8'd4, gw_ip}, 6);
      put(291, {8'd51, 8'd4, lease_sec}, 6);
      put(297, {8'd1, 8'd4, mask_reg}, 6);
      put(303, {8'd3, 8'd4, gw_ip}, 6);
      put(309, {8'd6, 8'd4, dns_ip}, 6);
      put(315, OPT_END, 1);
      sum = 0;
      for (int i = 14; i < 34; i += 2) sum += {txb[i], txb[i+1]};
      while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
      put(24, ~sum[15:0], 2);
      emit(342, kind);
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      int p, u, d, len;
      if (offset < 65535) begin
        p = offset;
        if (p == 12 || p == 13) eth_type = {eth_type[7:0], b};
        if (p == 20 || p == 21) arp_op = {arp_op[7:0], b};
        if (p >= 22 && p <= 27) snd_hw = {snd_hw[39:0], b};
        if (p >= 28 && p <= 31) snd_ip = {snd_ip[23:0], b};
        if (p >= 38 && p <= 41) tgt_ip = {tgt_ip[23:0], b};
        if (p == 14) ip_hdr_len = b[3:0] * 4;
        if (p == 23) proto = b;
        u = 14 + ip_hdr_len;
        d = u + 8;
        if (p == u + 2 || p == u + 3) udp_port = {udp_port[7:0], b};
        if (p >= d + 4 && p <= d + 7) xid = {xid[23:0], b};
        if (p >= d + 28 && p <= d + 33) cli_hw = {cli_hw[39:0], b};
        if (p >= d + 236 && p <= d + 239) cookie = {cookie[23:0], b};
        if (p >= d + 240) begin
          // serial option walk: code, length, data
          case (opt_phase)
            2'd0: if (opt_code != OPT_END && b != 0) begin
              opt_code = b;
              if (b != OPT_END) opt_phase = 1;
            end
            2'd1: if (b == 0) opt_phase = 0;
                  else begin opt_left = b; opt_phase = 2; end
            default: begin
              if (opt_phase == 2) type_seen = b;
              opt_left = opt_left - 1;
              if (opt_left == 0) begin
                if (opt_code == OPT_MSG_TYPE) dhcp_kind = type_seen;
                opt_phase = 0;
              end else opt_phase = 3;
            end
          endcase
        end
        offset++;
      end
      if (!eof) return;
      len = offset;
      if (len >= 14) begin
        if (eth_type == ETH_ARP) begin
          if (len >= 42 && arp_op == ARP_OP_REQ && (tgt_ip == gw_ip || tgt_ip == dns_ip)) begin
            foreach (txb[i]) txb[i] = 8'h00;
            put(0, snd_hw, 6); put(6, mac_reg, 6); put(12, ETH_ARP, 2);
            put(14, 1, 2); put(16, ETH_IPV4, 2); put(18, 16'h0604, 2); put(20, 2, 2);
            put(22, mac_reg, 6); put(28, tgt_ip, 4); put(32, snd_hw, 6); put(38, snd_ip, 4);
            emit(42, KIND_ARP);
          end
        end else if (eth_type == ETH_IPV4 && len >= 34 && proto == PROTO_UDP &&
                     len >= 22 + ip_hdr_len && udp_port == PORT_SERVER &&
                     len >= 262 + ip_hdr_len && cookie == DHCP_COOKIE) begin
          if (dhcp_kind == MSG_DISCOVER) build_dhcp(MSG_OFFER, KIND_OFFER);
          else if (dhcp_kind == MSG_REQUEST) build_dhcp(MSG_ACK, KIND_ACK);
        end
      end
      clear_frame();
    endfunction

    function void check_beat(reply_beat_t got);
      reply_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.word !== want.word || got.nbytes !== want.nbytes ||
          got.kind !== want.kind || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("beat mismatch: exp word %h n %0d kind %0d last %0b, got %h n %0d kind %0d last %0b",
                   want.word, want.nbytes, want.kind, want.last,
                   got.word, got.nbytes, got.kind, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  arpdhcp_in_if  in_ch ();
  arpdhcp_out_if out_ch ();
  arpdhcp_cfg_if cfg_ch ();

  arp_dhcp_reply_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  reply_scoreboard sb = new();
  int src_idle_pct = 14;
  int snk_idle_pct = 59;
  int snk_hold = 0;        // long receiver hold-off, in cycles
  int quiet_cycles = 0;
  logic [7:0] frame_q[$];

  // Monitors: every accepted frame byte feeds the predictor, every reply beat is checked.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.frame_byte, in_ch.end_of_frame);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.reply_word, out_ch.valid_bytes,
                     reply_kind_e'(out_ch.reply_kind), out_ch.last_word});
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (snk_hold > 0) begin
        snk_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.end_of_frame <= eof;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Drop valid, wait for all replies, then let a frame that makes no reply settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  // Holds valid up; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(logic [47:0] mac, logic [31:0] gw, logic [31:0] dns,
                           logic [31:0] lease, logic [31:0] mask, logic [31:0] secs);
    write_reg(CFG_BRIDGE_MAC, mac);
    write_reg(CFG_GATEWAY_IP, {16'h0, gw});
    write_reg(CFG_DNS_IP, {16'h0, dns});
    write_reg(CFG_LEASE_IP, {16'h0, lease});
    write_reg(CFG_SUBNET, {16'h0, mask});
    write_reg(CFG_LEASE_SEC, {16'h0, secs});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void set_field(int at, logic [47:0] v, int nb);
    for (int i = 0; i < nb; i++) if (at + i < frame_q.size()) frame_q[at + i] = v[8*(nb-1-i) +: 8];
  endfunction

  function automatic void fill_random(int len);
    frame_q = {};
    repeat (len) frame_q.push_back($urandom_range(255));
  endfunction

  function automatic void make_arp(logic [31:0] tgt, logic [15:0] op, int len);
    fill_random(len);
    set_field(12, ETH_ARP, 2);
    set_field(20, op, 2);
    set_field(38, tgt, 4);
  endfunction

  // DHCP frame; the option area mixes pads, other options, message type, end and junk.
  function automatic void make_dhcp(logic [3:0] ihl, logic [15:0] port, logic [31:0] cky,
                                    logic [7:0] mtype, bit cut);
    int d, olen, base;
    d = 22 + ihl * 4;
    fill_random(d + 240);
    set_field(12, ETH_IPV4, 2);
    set_field(14, {4'h4, ihl}, 1);
    set_field(23, PROTO_UDP, 1);
    set_field(16 + ihl * 4, port, 2);
    set_field(d + 236, cky, 4);
    base = frame_q.size();
    repeat ($urandom_range(2)) frame_q.push_back(8'h00);
    if ($urandom_range(1)) begin
      frame_q.push_back($urandom_range(1, 52));
      olen = $urandom_range(3);
      frame_q.push_back(olen);
      repeat (olen) frame_q.push_back($urandom_range(255));
    end
    frame_q.push_back(OPT_MSG_TYPE);
    olen = ($urandom_range(4) == 0) ? $urandom_range(3) : 1;
    frame_q.push_back(olen);
    if (olen > 0) frame_q.push_back(mtype);
    repeat (olen > 1 ? olen - 1 : 0) frame_q.push_back($urandom_range(255));
    if ($urandom_range(1)) frame_q.push_back(OPT_END);
    repeat ($urandom_range(8)) frame_q.push_back($urandom_range(255));
    if (cut) frame_q = frame_q[0 : base + $urandom_range(frame_q.size() - base - 1)];
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(5))
      0, 1: return MSG_DISCOVER;
      2, 3: return MSG_REQUEST;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_frame();
    int r;
    r = $urandom_range(9);
    if (r <= 2) begin
      make_arp($urandom_range(3) == 0 ? $urandom : ($urandom_range(1) ? sb.gw_ip : sb.dns_ip),
               $urandom_range(4) == 0 ? 16'($urandom) : ARP_OP_REQ,
               $urandom_range(3) == 0 ? $urandom_range(30, 60) : 42 + $urandom_range(18));
    end else if (r <= 6) begin
      make_dhcp($urandom_range(6) == 0 ? 4'($urandom) : 4'd5,
                $urandom_range(7) == 0 ? 16'($urandom) : PORT_SERVER,
                $urandom_range(7) == 0 ? 32'($urandom) : DHCP_COOKIE,
                pick_type(), $urandom_range(5) == 0);
    end else if (r == 7) begin
      fill_random($urandom_range(1, 20));
    end else begin
      fill_random($urandom_range(1, 80));
      if ($urandom_range(1)) set_field(12, $urandom_range(1) ? ETH_ARP : ETH_IPV4, 2);
    end
    send_frame();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.frame_byte = 8'h00;
    in_ch.end_of_frame = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BRIDGE_MAC;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the reset register values.
    make_arp(sb.gw_ip, ARP_OP_REQ, 42);   send_frame();
    make_arp(sb.dns_ip, ARP_OP_REQ, 60);  send_frame();
    make_arp(sb.gw_ip, 16'd2, 42);        send_frame();
    make_arp(32'h0A000209, ARP_OP_REQ, 42); send_frame();
    make_arp(sb.gw_ip, ARP_OP_REQ, 41);   send_frame();   // one byte short
    fill_random(13); set_field(12, ETH_ARP, 1); send_frame();  // under header length
    fill_random(1); send_frame();
    make_dhcp(4'd5, PORT_SERVER, DHCP_COOKIE, MSG_DISCOVER, 0); send_frame();
    make_dhcp(4'd5, PORT_SERVER, DHCP_COOKIE, MSG_REQUEST, 0);  send_frame();
    make_dhcp(4'd5, PORT_SERVER, 32'h63825364, MSG_DISCOVER, 0); send_frame();
    make_dhcp(4'd5, PORT_CLIENT, DHCP_COOKIE, MSG_DISCOVER, 0); send_frame();
    make_dhcp(4'd5, PORT_SERVER, DHCP_COOKIE, 8'd4, 0);         send_frame();
    make_dhcp(4'd6, PORT_SERVER, DHCP_COOKIE, MSG_REQUEST, 0);  send_frame();  // long IP header
    make_dhcp(4'd0, PORT_SERVER, DHCP_COOKIE, MSG_DISCOVER, 0); send_frame();  // zero IHL
    make_dhcp(4'd15, PORT_SERVER, DHCP_COOKIE, MSG_REQUEST, 1); send_frame();  // truncated option
    // End option ahead of the message type: walk stops, no reply.
    make_dhcp(4'd5, PORT_SERVER, DHCP_COOKIE, MSG_DISCOVER, 0);
    frame_q[282] = OPT_END; send_frame();
    // Oversize frame: offset saturates, the trailing bytes are dropped.
    make_arp(sb.gw_ip, ARP_OP_REQ, 42);
    repeat (65540 - 42) frame_q.push_back($urandom_range(255));
    send_frame();
    drain();

    // Register extremes, random values, then the reset values; the last two settings share one idling profile.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_all('0, '0, '0, '0, '0, '0);
        1: write_all('1, '1, 32'hFFFFFFFE, '1, '1, '1);
        2: write_all(48'({$urandom, $urandom}), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        default: write_all(48'h02005E100002, 32'h0A000202, 32'h0A000203,
                           32'h0A00020F, 32'hFFFFFF00, 32'd86400);
      endcase
      case (phase)
        0: begin src_idle_pct = 14; snk_idle_pct = 59; end
        1: begin src_idle_pct = 59; snk_idle_pct = 14; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      repeat (30) random_frame();
      if (phase == 1) begin
        // Receiver holds off while several DHCP requests pile up behind it.
        snk_hold = 400;
        repeat (4) begin
          make_dhcp(4'd5, PORT_SERVER, DHCP_COOKIE, MSG_REQUEST, 0);
          send_frame();
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/arpdhcp_pkg.sv
design/arpdhcp_if.sv
design/arpdhcp_front.sv
design/arpdhcp_queue.sv
design/arpdhcp_back.sv
design/arp_dhcp_reply_engine.sv
dv/arp_dhcp_reply_engine_test.sv
